@@ src/tcw_pkg.sv @@
// tcw_pkg: shared types and constants for the text console writer.
// Payload structs, op and character codes, config indexes and reset values.
// No dependencies.
package tcw_pkg;

    localparam int IDX_W = 17;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] CFG_ATTR = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_ROWS = 2'd2;

    localparam logic [7:0] ATTR_RST = 8'd15;
    localparam logic [7:0] COLS_RST = 8'd80;
    localparam logic [7:0] ROWS_RST = 8'd25;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [11:0] read_address;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [7:0]  cursor_row;
        logic [7:0]  cursor_col;
        logic        scrolled;
    } out_item_t;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
        logic       put_cell;
        logic       scroll;
    } cursor_step_t;

endpackage

@@ src/tcw_cursor_step.sv @@
// tcw_cursor_step: next cursor position for one put-character item.
// Handles newline, carriage return, tab, line wrap and bottom-of-screen scroll.
// Depends on tcw_pkg.
module tcw_cursor_step #(
    parameter int TAB_STEP = 8
) (
    input  logic [7:0]           row,
    input  logic [7:0]           col,
    input  logic [7:0]           char_code,
    input  logic [7:0]           cols_eff,
    input  logic [7:0]           rows_eff,
    output tcw_pkg::cursor_step_t step
);

    localparam logic [8:0] TAB_INC = 9'(TAB_STEP);

    always_comb
    begin
        logic [8:0] col_adv;
        logic [8:0] row_adv;
        logic       line;

        step.put_cell = 1'b0;
        step.scroll   = 1'b0;
        step.row      = row;
        step.col      = col;
        line          = 1'b0;
        col_adv = (char_code == tcw_pkg::CH_TAB) ? ({1'b0, col} + TAB_INC)
                                                 : ({1'b0, col} + 9'd1);
        row_adv = {1'b0, row} + 9'd1;

        case (char_code)
            tcw_pkg::CH_LF:
            begin
                line = 1'b1;
            end
            tcw_pkg::CH_CR:
            begin
                step.col = 8'd0;
            end
            default:
            begin
                step.put_cell = (char_code != tcw_pkg::CH_TAB);
                if (col_adv >= {1'b0, cols_eff})
                begin
                    step.col = 8'd0;
                    line     = 1'b1;
                end
                else
                begin
                    step.col = col_adv[7:0];
                end
            end
        endcase

        if (line)
        begin
            if (row_adv >= {1'b0, rows_eff})
            begin
                step.row    = rows_eff - 8'd1;
                step.scroll = 1'b1;
            end
            else
            begin
                step.row = row_adv[7:0];
            end
        end
    end

endmodule

@@ src/text_console_writer_core.sv @@
// text_console_writer_core: character-cell console with cell memory and cursor.
// Put: S_CALC forms row*cols, then S_WRITE writes the cell and steps the cursor. Read: wraps
// the address into CELLS, then reads the cell. Clear blanks every cell and homes the cursor.
// A scroll copies each cell up one row over one memory port pair and blanks the last row.
// One transfer in flight; a new one is taken while a result waits.
// Reset: cursor home, attribute 15, 80 columns, 25 rows; cell memory undefined.
module text_console_writer_core #(
    parameter int CELLS    = 4096,
    parameter int TAB_STEP = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcw_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tcw_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int AW = $clog2(CELLS);
    localparam int IW = tcw_pkg::IDX_W;
    localparam logic [IW-1:0] CELL_LIM = IW'(CELLS);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_CALC      = 13'b0000000000010,
        S_WRITE     = 13'b0000000000100,
        S_SCR_MUL   = 13'b0000000001000,
        S_SCR_END   = 13'b0000000010000,
        S_SCR_RD    = 13'b0000000100000,
        S_SCR_WR    = 13'b0000001000000,
        S_SCR_BLANK = 13'b0000010000000,
        S_CLEAR     = 13'b0000100000000,
        S_RD_MOD    = 13'b0001000000000,
        S_RD_DATA   = 13'b0010000000000,
        S_DONE      = 13'b0100000000000,
        S_SPARE     = 13'b1000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         char_reg, char_next;
    logic [IW-1:0]      addr_reg, addr_next;
    logic [7:0]         row_reg, row_next;
    logic [7:0]         col_reg, col_next;
    logic [15:0]        prod_reg, prod_next;
    logic [15:0]        limit_reg, limit_next;
    logic [IW-1:0]      end_reg, end_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               src_ok_reg, src_ok_next;
    logic [15:0]        cell_reg, cell_next;
    logic               scrolled_reg, scrolled_next;
    logic               out_valid_reg, out_valid_next;
    tcw_pkg::out_item_t out_data_reg, out_data_next;
    logic [7:0]         attr_reg, cols_reg, rows_reg;
    logic [15:0]        rdata_reg;

    logic [15:0]        screen_mem [CELLS];

    logic [7:0]         cols_eff, rows_eff;
    logic [15:0]        blank;
    logic [IW-1:0]      wr_idx, src_idx, scroll_end;
    logic               mem_we, mem_re;
    logic [IW-1:0]      mem_waddr, mem_raddr;
    logic [15:0]        mem_wdata;
    tcw_pkg::cursor_step_t step;

    assign cols_eff   = (cols_reg == 8'd0) ? 8'd1 : cols_reg;
    assign rows_eff   = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
    assign blank      = {attr_reg, tcw_pkg::CH_SPACE};
    assign wr_idx     = IW'(prod_reg) + IW'(col_reg);
    assign src_idx    = idx_reg + IW'(cols_eff);
    assign scroll_end = IW'(limit_reg) + IW'(cols_eff);

    tcw_cursor_step #(
        .TAB_STEP (TAB_STEP)
    ) u_step (
        .row       (row_reg),
        .col       (col_reg),
        .char_code (char_reg),
        .cols_eff  (cols_eff),
        .rows_eff  (rows_eff),
        .step      (step)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        char_next      = char_reg;
        addr_next      = addr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        prod_next      = prod_reg;
        limit_next     = limit_reg;
        end_next       = end_reg;
        idx_next       = idx_reg;
        src_ok_next    = src_ok_reg;
        cell_next      = cell_reg;
        scrolled_next  = scrolled_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = idx_reg;
        mem_raddr      = src_idx;
        mem_wdata      = blank;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    char_next     = in_data.char_code;
                    addr_next     = IW'(in_data.read_address);
                    cell_next     = 16'd0;
                    scrolled_next = 1'b0;
                    idx_next      = '0;
                    case (in_data.op)
                        tcw_pkg::OP_PUT:   state_next = S_CALC;
                        tcw_pkg::OP_CLEAR: state_next = S_CLEAR;
                        tcw_pkg::OP_READ:  state_next = S_RD_MOD;
                        tcw_pkg::OP_NOP:   state_next = S_DONE;
                        default:           state_next = S_DONE;
                    endcase
                end
            end
            S_CALC:
            begin
                prod_next  = 16'(row_reg) * 16'(cols_eff);
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                mem_we        = step.put_cell && (wr_idx < CELL_LIM);
                mem_waddr     = wr_idx;
                mem_wdata     = {attr_reg, char_reg};
                row_next      = step.row;
                col_next      = step.col;
                scrolled_next = step.scroll;
                state_next    = step.scroll ? S_SCR_MUL : S_DONE;
            end
            S_SCR_MUL:
            begin
                limit_next = 16'(cols_eff) * 16'(rows_eff - 8'd1);
                state_next = S_SCR_END;
            end
            S_SCR_END:
            begin
                end_next   = (scroll_end < CELL_LIM) ? scroll_end : CELL_LIM;
                idx_next   = '0;
                state_next = S_SCR_RD;
            end
            S_SCR_RD:
            begin
                if (idx_reg >= end_reg)
                begin
                    state_next = S_DONE;
                end
                else if (idx_reg < IW'(limit_reg))
                begin
                    mem_re      = (src_idx < CELL_LIM);
                    mem_raddr   = src_idx;
                    src_ok_next = (src_idx < CELL_LIM);
                    state_next  = S_SCR_WR;
                end
                else
                begin
                    state_next = S_SCR_BLANK;
                end
            end
            S_SCR_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = src_ok_reg ? rdata_reg : 16'd0;
                idx_next   = idx_reg + IW'(1);
                state_next = S_SCR_RD;
            end
            S_SCR_BLANK:
            begin
                if (idx_reg >= end_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    idx_next  = idx_reg + IW'(1);
                end
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                idx_next  = idx_reg + IW'(1);
                if (idx_reg == CELL_LIM - IW'(1))
                begin
                    row_next   = 8'd0;
                    col_next   = 8'd0;
                    state_next = S_DONE;
                end
            end
            S_RD_MOD:
            begin
                if (addr_reg >= CELL_LIM)
                begin
                    addr_next = addr_reg - CELL_LIM;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = addr_reg;
                    state_next = S_RD_DATA;
                end
            end
            S_RD_DATA:
            begin
                cell_next  = rdata_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.cell_value = cell_reg;
                    out_data_next.cursor_row = row_reg;
                    out_data_next.cursor_col = col_reg;
                    out_data_next.scrolled   = scrolled_reg;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= 8'd0;
            col_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
            attr_reg      <= tcw_pkg::ATTR_RST;
            cols_reg      <= tcw_pkg::COLS_RST;
            rows_reg      <= tcw_pkg::ROWS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tcw_pkg::CFG_ATTR: attr_reg <= cfg_data;
                    tcw_pkg::CFG_COLS: cols_reg <= cfg_data;
                    tcw_pkg::CFG_ROWS: rows_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        addr_reg     <= addr_next;
        prod_reg     <= prod_next;
        limit_reg    <= limit_next;
        end_reg      <= end_next;
        idx_reg      <= idx_next;
        src_ok_reg   <= src_ok_next;
        cell_reg     <= cell_next;
        scrolled_reg <= scrolled_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_raddr[AW-1:0]];
        end
    end

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again during item work");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> mem_waddr < CELL_LIM)
        else $error("cell write outside memory");

    a_scroll_clamps_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.scrolled |-> out_data.cursor_row == rows_eff - 8'd1)
        else $error("scrolled result without cursor on last line");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

endmodule
